// File: src/mqg_pkg.sv
// ----------------------------------------------------------------------------
// mqg_pkg
// Shared types, codes and helpers for the quadrature mouse generator.
// ----------------------------------------------------------------------------
package mqg_pkg;

  // Event codes as they arrive on the func port.
  localparam logic [2:0] FUNC_SET_POS   = 3'd0;
  localparam logic [2:0] FUNC_ADD_DELTA = 3'd1;
  localparam logic [2:0] FUNC_SET_BTN   = 3'd2;
  localparam logic [2:0] FUNC_TICK      = 3'd3;
  localparam logic [2:0] FUNC_IMPULSE   = 3'd4;

  // Accumulators chase the target shifted right by this amount.
  localparam int unsigned SCALE_SHIFT = 3;

  // Command queue geometry. The depth must be a power of two.
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned FIFO_DEPTH = 1 << PTR_W;

  // Commands carried from the front end to the execution unit.
  typedef enum logic [1:0] {
    OP_SET_POS,
    OP_ADD,
    OP_SET_BTN,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] dx;
    logic [31:0] dy;
    logic        pressed;
  } cmd_t;

  // Gray-coded phase for the low two bits of an accumulator.
  function automatic logic [1:0] gray_phase(input logic [1:0] pos);
    logic [1:0] ph;
    unique case (pos)
      2'd0: ph = 2'b00;
      2'd1: ph = 2'b10;
      2'd2: ph = 2'b11;
      2'd3: ph = 2'b01;
      default: ph = 2'b00;
    endcase
    return ph;
  endfunction

endpackage

// File: src/mqg_front.sv
// ----------------------------------------------------------------------------
// mqg_front
// Accepts events and turns them into queue commands. Impulses become
// one-axis deltas; second-button and spare-code events are dropped here.
// ----------------------------------------------------------------------------
module mqg_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               which,
  input  logic               button_state,
  input  logic               queue_full,
  output logic               push,
  output mqg_pkg::cmd_t      push_data
);

  logic keep;

  // Classify the event and shape its payload.
  always_comb begin
    keep              = 1'b1;
    push_data.op      = mqg_pkg::OP_ADD;
    push_data.dx      = x_value;
    push_data.dy      = y_value;
    push_data.pressed = button_state;
    unique case (func)
      mqg_pkg::FUNC_SET_POS: begin
        push_data.op = mqg_pkg::OP_SET_POS;
      end
      mqg_pkg::FUNC_ADD_DELTA: begin
        push_data.op = mqg_pkg::OP_ADD;
      end
      mqg_pkg::FUNC_SET_BTN: begin
        // Only the primary button is tracked.
        push_data.op = mqg_pkg::OP_SET_BTN;
        keep         = ~which;
      end
      mqg_pkg::FUNC_TICK: begin
        push_data.op = mqg_pkg::OP_TICK;
      end
      mqg_pkg::FUNC_IMPULSE: begin
        // The impulse amount always comes in on x_value.
        push_data.op = mqg_pkg::OP_ADD;
        if (which) begin
          push_data.dx = 32'd0;
          push_data.dy = x_value;
        end else begin
          push_data.dx = x_value;
          push_data.dy = 32'd0;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Handshake toward the queue.
  assign in_ready = ~queue_full;
  assign push     = in_valid & in_ready & keep;

endmodule

// File: src/mqg_fifo.sv
// ----------------------------------------------------------------------------
// mqg_fifo
// Small command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module mqg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mqg_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output mqg_pkg::cmd_t pop_data,
  output logic          empty
);

  mqg_pkg::cmd_t                entries [mqg_pkg::FIFO_DEPTH];
  logic [mqg_pkg::PTR_W-1:0]    wr_ptr;
  logic [mqg_pkg::PTR_W-1:0]    rd_ptr;
  logic [mqg_pkg::PTR_W:0]      count;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data = entries[rd_ptr];
  assign empty    = (count == '0);
  assign full     = (count == (mqg_pkg::PTR_W + 1)'(mqg_pkg::FIFO_DEPTH));

endmodule

// File: src/mqg_back.sv
// ----------------------------------------------------------------------------
// mqg_back
// Executes queued commands on the target, accumulator and button state and
// holds a tick's result in an output register until it is taken.
// ----------------------------------------------------------------------------
module mqg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  mqg_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    quad_bits,
  output logic          button_bit
);

  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [31:0] accum_x;
  logic [31:0] accum_y;
  logic        button_held;

  logic [31:0] goal_x;
  logic [31:0] goal_y;
  logic [31:0] accum_x_next;
  logic [31:0] accum_y_next;
  logic        moved;
  logic        is_tick;

  // A tick waits only while an untaken result holds the output register.
  assign is_tick = (cmd.op == mqg_pkg::OP_TICK);
  assign pop     = ~empty & (~is_tick | ~out_valid | out_ready);

  // One step of each accumulator toward its scaled target.
  always_comb begin
    goal_x = 32'($signed(target_x) >>> mqg_pkg::SCALE_SHIFT);
    goal_y = 32'($signed(target_y) >>> mqg_pkg::SCALE_SHIFT);

    if (accum_x == goal_x) begin
      accum_x_next = accum_x;
    end else if ($signed(accum_x) < $signed(goal_x)) begin
      accum_x_next = accum_x + 32'd1;
    end else begin
      accum_x_next = accum_x - 32'd1;
    end

    if (accum_y == goal_y) begin
      accum_y_next = accum_y;
    end else if ($signed(accum_y) < $signed(goal_y)) begin
      accum_y_next = accum_y + 32'd1;
    end else begin
      accum_y_next = accum_y - 32'd1;
    end

    moved = (accum_x != goal_x) | (accum_y != goal_y);
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x    <= '0;
      target_y    <= '0;
      accum_x     <= '0;
      accum_y     <= '0;
      button_held <= 1'b0;
    end else if (pop) begin
      unique case (cmd.op)
        mqg_pkg::OP_SET_POS: begin
          target_x <= cmd.dx;
          target_y <= cmd.dy;
        end
        mqg_pkg::OP_ADD: begin
          target_x <= target_x + cmd.dx;
          target_y <= target_y + cmd.dy;
        end
        mqg_pkg::OP_SET_BTN: begin
          button_held <= cmd.pressed;
        end
        mqg_pkg::OP_TICK: begin
          accum_x <= accum_x_next;
          accum_y <= accum_y_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_tick && moved) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload, loaded only when a tick moved an axis.
  always_ff @(posedge clk) begin
    if (pop && is_tick && moved) begin
      quad_bits  <= {mqg_pkg::gray_phase(accum_y_next[1:0]),
                     mqg_pkg::gray_phase(accum_x_next[1:0])};
      button_bit <= button_held;
    end
  end

endmodule

// File: src/mouse_quadrature_generator_top.sv
// Flow: a tick that moves an axis is written into the command queue, then
// executed into the output register, which raises out_valid; other events give no item.
// Throughput: one item per cycle while no untaken result stalls a tick;
// a four-entry command queue absorbs output stalls.
// Reset: synchronous rst clears targets, accumulators, button and queue.
// ----------------------------------------------------------------------------
// mouse_quadrature_generator_top
// Quadrature mouse emulation: front end, command queue and execution unit.
// ----------------------------------------------------------------------------
module mouse_quadrature_generator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               which,
  input  logic               button_state,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         quad_bits,
  output logic               button_bit
);

  logic          queue_full;
  logic          queue_empty;
  logic          push;
  logic          pop;
  mqg_pkg::cmd_t push_data;
  mqg_pkg::cmd_t pop_data;

  // Event classification.
  mqg_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .x_value      (x_value),
    .y_value      (y_value),
    .which        (which),
    .button_state (button_state),
    .queue_full   (queue_full),
    .push         (push),
    .push_data    (push_data)
  );

  // Command queue.
  mqg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  // Execution and output register.
  mqg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .cmd        (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .quad_bits  (quad_bits),
    .button_bit (button_bit)
  );

endmodule

// File: tb/mqg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mqg_checker
// Watches both channels of the quadrature mouse generator. Keeps its own copy
// of the targets, accumulators and button, models every accepted event,
// predicts a report for each tick that moves an axis and compares each
// accepted report with the oldest prediction.
// ----------------------------------------------------------------------------
module mqg_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] y_value,
  input  logic               which,
  input  logic               button_state,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [3:0]         quad_bits,
  input  logic               button_bit,
  output int                 fail_count,
  output int                 pending,
  output int                 reports_checked,
  output int                 settled_ticks
);

  // One predicted movement report.
  typedef struct packed {
    logic [3:0] quad;
    logic       button;
  } report_t;

  // Phase sequence for the low two bits of a position, one bit change per step.
  localparam logic [1:0] GRAY_SEQ [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

  report_t            expected_reports[$];
  logic signed [31:0] tgt_x, tgt_y;
  logic signed [31:0] pos_x, pos_y;
  logic               btn_down;

  // Next accumulator value: one step toward the scaled target, or no change.
  function automatic logic signed [31:0] chase(input logic signed [31:0] acc,
                                               input logic signed [31:0] tgt);
    logic signed [31:0] goal;
    goal = tgt >>> mqg_pkg::SCALE_SHIFT;
    if (acc == goal) return acc;
    if (acc < goal) return acc + 32'sd1;
    return acc - 32'sd1;
  endfunction

  // Reports are compared before the same edge's event is modeled, so a
  // report can never be matched against an event accepted at that edge.
  always @(posedge clk) begin : monitor
    report_t            want;
    logic signed [31:0] nx, ny;
    if (rst) begin
      tgt_x           = '0;
      tgt_y           = '0;
      pos_x           = '0;
      pos_y           = '0;
      btn_down        = 1'b0;
      fail_count      = 0;
      reports_checked = 0;
      settled_ticks   = 0;
      expected_reports.delete();
    end else begin
      // Compare an accepted report with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: quad_bits %h button_bit %b", quad_bits, button_bit);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (quad_bits !== want.quad) begin
            $error("quad_bits: expected %h, got %h", want.quad, quad_bits);
            fail_count++;
          end
          if (button_bit !== want.button) begin
            $error("button_bit: expected %b, got %b", want.button, button_bit);
            fail_count++;
          end
          reports_checked++;
        end
      end
      // Model the accepted event.
      if (in_valid && in_ready) begin
        case (func)
          mqg_pkg::FUNC_SET_POS: begin
            tgt_x = x_value;
            tgt_y = y_value;
          end
          mqg_pkg::FUNC_ADD_DELTA: begin
            tgt_x = tgt_x + x_value;
            tgt_y = tgt_y + y_value;
          end
          mqg_pkg::FUNC_SET_BTN: begin
            // Only the primary button is tracked.
            if (!which) btn_down = button_state;
          end
          mqg_pkg::FUNC_IMPULSE: begin
            if (!which) tgt_x = tgt_x + x_value;
            else tgt_y = tgt_y + x_value;
          end
          mqg_pkg::FUNC_TICK: begin
            nx = chase(pos_x, tgt_x);
            ny = chase(pos_y, tgt_y);
            if (nx != pos_x || ny != pos_y) begin
              want.quad   = {GRAY_SEQ[ny[1:0]], GRAY_SEQ[nx[1:0]]};
              want.button = btn_down;
              expected_reports = {expected_reports, want};
            end else begin
              settled_ticks++;
            end
            pos_x = nx;
            pos_y = ny;
          end
          default: begin
            // Spare codes leave everything as it is.
          end
        endcase
      end
    end
    pending = expected_reports.size();
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives events into the quadrature mouse generator: a directed pass over
// position extremes, wraparound, both buttons, impulses on both axes and the
// spare codes, then bursts of random events with random output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  // Codes the block does not use.
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  localparam int RANDOM_EVENTS = 1830;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic signed [31:0] POS_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] POS_MIN = 32'sh80000000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         func;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               which;
  logic               button_state;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [3:0]         quad_bits;
  logic               button_bit;

  int fail_count;
  int pending;
  int reports_checked;
  int settled_ticks;
  int events_sent;
  int burst_left;
  int cycle_count = 0;
  int rx_mode     = 0;
  int mode_left   = 0;

  mouse_quadrature_generator_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .x_value      (x_value),
    .y_value      (y_value),
    .which        (which),
    .button_state (button_state),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .quad_bits    (quad_bits),
    .button_bit   (button_bit)
  );

  mqg_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .x_value         (x_value),
    .y_value         (y_value),
    .which           (which),
    .button_state    (button_state),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .quad_bits       (quad_bits),
    .button_bit      (button_bit),
    .fail_count      (fail_count),
    .pending         (pending),
    .reports_checked (reports_checked),
    .settled_ticks   (settled_ticks)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: switches between always ready, mostly ready and sparse ready.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 100);
    end
    mode_left--;
    case (rx_mode)
      0:       out_ready = 1'b1;
      1:       out_ready = ($urandom_range(0, 9) < 7);
      default: out_ready = ($urandom_range(0, 5) == 0);
    endcase
  end

  // Present one event, hold it until accepted, then maybe leave a gap.
  task automatic send_event(input logic [2:0] f, input logic signed [31:0] xv,
                            input logic signed [31:0] yv, input logic w,
                            input logic b);
    int gap;
    in_valid     = 1'b1;
    func         = f;
    x_value      = xv;
    y_value      = yv;
    which        = w;
    button_state = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    events_sent++;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every predicted report has arrived.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Small signed value in [-span, span].
  function automatic logic signed [31:0] near_zero(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // One random bit.
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // One random event, weighted toward ticks and small moves so that the
  // accumulators keep catching up with their goals.
  task automatic send_random_event();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)
      send_event(mqg_pkg::FUNC_TICK, $urandom, $urandom, coin(), coin());
    else if (roll < 60)
      send_event(mqg_pkg::FUNC_ADD_DELTA, near_zero(64), near_zero(64), coin(), coin());
    else if (roll < 70)
      send_event(mqg_pkg::FUNC_IMPULSE, near_zero(64), $urandom, coin(), coin());
    else if (roll < 78)
      send_event(mqg_pkg::FUNC_SET_POS, near_zero(256), near_zero(256), coin(), coin());
    else if (roll < 88)
      send_event(mqg_pkg::FUNC_SET_BTN, $urandom, $urandom, coin(), coin());
    else if (roll < 94)
      send_event(($urandom_range(0, 2) == 0) ? mqg_pkg::FUNC_SET_POS :
                 ($urandom_range(0, 1) == 0) ? mqg_pkg::FUNC_ADD_DELTA :
                 mqg_pkg::FUNC_IMPULSE,
                 $urandom, $urandom, coin(), coin());
    else
      send_event(3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)), $urandom, $urandom,
                 coin(), coin());
  endtask

  // Stimulus and verdict.
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = mqg_pkg::FUNC_TICK;
    x_value      = '0;
    y_value      = '0;
    which        = 1'b0;
    button_state = 1'b0;
    events_sent  = 0;
    burst_left   = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: a tick right after reset has nowhere to go.
    send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_SET_BTN, 0, 0, 1'b0, 1'b1);
    send_event(mqg_pkg::FUNC_SET_POS, 24, -24, 1'b0, 1'b0);
    repeat (4) send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    // The second button must not touch the reported button.
    send_event(mqg_pkg::FUNC_SET_BTN, 0, 0, 1'b1, 1'b0);
    send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    // Position extremes, then wraparound of both targets.
    send_event(mqg_pkg::FUNC_SET_POS, POS_MAX, POS_MIN, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_ADD_DELTA, 1, -1, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    // Impulses on each axis, one of them wrapping.
    send_event(mqg_pkg::FUNC_IMPULSE, -1, 0, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_IMPULSE, POS_MIN, POS_MAX, 1'b1, 1'b1);
    send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    // Spare codes with all-ones payload change nothing.
    for (int c = FUNC_SPARE_LO; c <= FUNC_SPARE_HI; c++)
      send_event(3'(c), -1, -1, 1'b1, 1'b1);
    send_event(mqg_pkg::FUNC_SET_POS, 0, 0, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_SET_BTN, 0, 0, 1'b0, 1'b0);
    send_event(mqg_pkg::FUNC_TICK, 0, 0, 1'b0, 1'b0);
    wait_drained();

    // Random bursts, with one full drain halfway through.
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n == RANDOM_EVENTS / 2) wait_drained();
      send_random_event();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d events (directed corners, then random bursts with output stalls);",
             events_sent);
    $display("checked %0d movement reports and saw %0d ticks with both axes settled.",
             reports_checked, settled_ticks);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
